/* sv/rvex_pkg.sv */
// Shared opcodes, function codes and payload types of the RV32I execute unit.
package rvex_pkg;

  // Major opcodes of the supported instruction groups.
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;

  // ALU function codes.
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // Branch condition codes.
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  // Memory access kind and width codes.
  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_LOAD  = 2'd1;
  localparam logic [1:0] MEM_STORE = 2'd2;

  localparam logic [1:0] MW_BYTE = 2'd0;
  localparam logic [1:0] MW_HALF = 2'd1;
  localparam logic [1:0] MW_WORD = 2'd2;

  // Fields of one request.
  typedef struct packed {
    logic [31:0] instr_word;
    logic [31:0] cur_pc;
    logic [31:0] src1_value;
    logic [31:0] src2_value;
  } ex_req_t;

  // Fields of one result.
  typedef struct packed {
    logic [4:0]  dest_index;
    logic        dest_write;
    logic [31:0] result_value;
    logic [31:0] next_pc;
    logic        branch_taken;
    logic [1:0]  mem_kind;
    logic [1:0]  mem_width;
    logic        mem_zero_extend;
    logic [31:0] mem_address;
    logic [31:0] store_value;
    logic        unknown_opcode;
  } ex_res_t;

  // Control of the ALU and comparator.
  typedef struct packed {
    logic [2:0] funct3;
    logic       sub_en;
    logic       sra_en;
  } alu_ctl_t;

endpackage

/* sv/rvex_ifs.sv */
// Request and result channel interfaces of the RV32I execute unit.
interface rvex_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_word;
  logic [31:0] cur_pc;
  logic [31:0] src1_value;
  logic [31:0] src2_value;

  modport source (output valid, instr_word, cur_pc, src1_value, src2_value, input ready);
  modport sink   (input valid, instr_word, cur_pc, src1_value, src2_value, output ready);
endinterface

interface rvex_res_if;
  logic        valid;
  logic        ready;
  logic [4:0]  dest_index;
  logic        dest_write;
  logic [31:0] result_value;
  logic [31:0] next_pc;
  logic        branch_taken;
  logic [1:0]  mem_kind;
  logic [1:0]  mem_width;
  logic        mem_zero_extend;
  logic [31:0] mem_address;
  logic [31:0] store_value;
  logic        unknown_opcode;

  modport source (output valid, dest_index, dest_write, result_value, next_pc, branch_taken,
                  mem_kind, mem_width, mem_zero_extend, mem_address, store_value,
                  unknown_opcode, input ready);
  modport sink   (input valid, dest_index, dest_write, result_value, next_pc, branch_taken,
                  mem_kind, mem_width, mem_zero_extend, mem_address, store_value,
                  unknown_opcode, output ready);
endinterface

/* sv/rvex_alu.sv */
// Integer ALU and branch comparator of the RV32I execute unit.
module rvex_alu import rvex_pkg::*; (
  input  alu_ctl_t    ctl,
  input  logic [31:0] op_a,
  input  logic [31:0] op_b,
  output logic [31:0] result,
  output logic        branch_cond
);

  logic [4:0] shamt;
  logic       eq;
  logic       lt_s;
  logic       lt_u;

  // Shared comparisons serve both set-less-than and branches.
  assign shamt = op_b[4:0];
  assign eq    = (op_a == op_b);
  assign lt_s  = ($signed(op_a) < $signed(op_b));
  assign lt_u  = (op_a < op_b);

  // Arithmetic and logic result.
  always_comb begin
    case (ctl.funct3)
      F3_ADD:  result = ctl.sub_en ? (op_a - op_b) : (op_a + op_b);
      F3_SLL:  result = op_a << shamt;
      F3_SLT:  result = {31'd0, lt_s};
      F3_SLTU: result = {31'd0, lt_u};
      F3_XOR:  result = op_a ^ op_b;
      F3_SR:   result = ctl.sra_en ? 32'($signed(op_a) >>> shamt) : (op_a >> shamt);
      F3_OR:   result = op_a | op_b;
      F3_AND:  result = op_a & op_b;
      default: result = op_a & op_b;
    endcase
  end

  // Branch condition; the two unused codes never branch.
  always_comb begin
    case (ctl.funct3)
      F3_BEQ:  branch_cond = eq;
      F3_BNE:  branch_cond = !eq;
      F3_BLT:  branch_cond = lt_s;
      F3_BGE:  branch_cond = !lt_s;
      F3_BLTU: branch_cond = lt_u;
      F3_BGEU: branch_cond = !lt_u;
      default: branch_cond = 1'b0;
    endcase
  end

endmodule

/* sv/rv32i_execute_unit.sv */
// Top level of the RV32I execute unit: request register, decode and execute, result register.
//
//   Channel  Direction  Carries
//   in_req   sink       instr_word, cur_pc, src1_value, src2_value
//   out_res  source     rd, write enable, result, next pc, branch and memory fields, flag
//
// Each request gives one result, passing through the request register and then the result
// register; a new request can be taken every cycle unless the result channel stalls.
// Reset clears both valid flags, so no result is shown until a request has been taken.
// A stalled result holds the result register; the request register keeps filling until
// it too is occupied, and only then does in_req.ready fall.
module rv32i_execute_unit import rvex_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  rvex_req_if.sink   in_req,
  rvex_res_if.source out_res
);

  logic        s1_valid_r;
  ex_req_t     s1_req_r;
  logic        out_valid_r;
  ex_res_t     res_r;
  ex_res_t     res_nxt;
  logic        out_adv;
  logic        s1_adv;

  logic [31:0] ins;
  logic [6:0]  opc;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_u;
  logic [31:0] imm_j;
  logic [31:0] pc_off;
  logic [31:0] pc_sum;
  logic [31:0] pc_inc;
  logic [31:0] addr_sum;
  logic [31:0] alu_b;
  logic [31:0] alu_res;
  logic        br_cond;
  logic [1:0]  acc_width;
  logic        writes;
  alu_ctl_t    alu_ctl;

  // Handshake: each register advances when the one after it can take its contents.
  assign out_adv      = !out_valid_r || out_res.ready;
  assign s1_adv       = !s1_valid_r || out_adv;
  assign in_req.ready = s1_adv;

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_r <= in_req.valid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s1_adv && in_req.valid) begin
      s1_req_r.instr_word <= in_req.instr_word;
      s1_req_r.cur_pc     <= in_req.cur_pc;
      s1_req_r.src1_value <= in_req.src1_value;
      s1_req_r.src2_value <= in_req.src2_value;
    end
    if (out_adv && s1_valid_r) begin
      res_r <= res_nxt;
    end
  end

  // Instruction fields and immediates.
  assign ins   = s1_req_r.instr_word;
  assign opc   = ins[6:0];
  assign rd    = ins[11:7];
  assign f3    = ins[14:12];
  assign imm_i = {{20{ins[31]}}, ins[31:20]};
  assign imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
  assign imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
  assign imm_u = {ins[31:12], 12'd0};
  assign imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};

  // One pc-relative adder serves AUIPC, JAL and taken branches.
  always_comb begin
    case (opc)
      OPC_AUIPC: pc_off = imm_u;
      OPC_JAL:   pc_off = imm_j;
      default:   pc_off = imm_b;
    endcase
  end

  assign pc_sum   = s1_req_r.cur_pc + pc_off;
  assign pc_inc   = s1_req_r.cur_pc + 32'd4;
  assign addr_sum = s1_req_r.src1_value + ((opc == OPC_STORE) ? imm_s : imm_i);

  // Access width: the spare code three reads as a word.
  assign acc_width = (f3[1:0] == 2'd3) ? MW_WORD : f3[1:0];

  // ALU operands and control.
  assign alu_b          = ((opc == OPC_OP) || (opc == OPC_BRANCH)) ? s1_req_r.src2_value
                                                                  : imm_i;
  assign alu_ctl.funct3 = f3;
  assign alu_ctl.sub_en = (opc == OPC_OP) && ins[30];
  assign alu_ctl.sra_en = ins[30];

  rvex_alu u_alu (
    .ctl         (alu_ctl),
    .op_a        (s1_req_r.src1_value),
    .op_b        (alu_b),
    .result      (alu_res),
    .branch_cond (br_cond)
  );

  // Decode and result selection.
  always_comb begin
    res_nxt                 = '0;
    res_nxt.next_pc         = pc_inc;
    writes                  = 1'b0;
    case (opc)
      OPC_LUI: begin
        res_nxt.dest_index   = rd;
        res_nxt.result_value = imm_u;
        writes               = 1'b1;
      end
      OPC_AUIPC: begin
        res_nxt.dest_index   = rd;
        res_nxt.result_value = pc_sum;
        writes               = 1'b1;
      end
      OPC_JAL: begin
        res_nxt.dest_index   = rd;
        res_nxt.result_value = pc_inc;
        res_nxt.next_pc      = pc_sum;
        writes               = 1'b1;
      end
      OPC_JALR: begin
        res_nxt.dest_index   = rd;
        res_nxt.result_value = pc_inc;
        res_nxt.next_pc      = {addr_sum[31:1], 1'b0};
        writes               = 1'b1;
      end
      OPC_BRANCH: begin
        if (br_cond) begin
          res_nxt.branch_taken = 1'b1;
          res_nxt.next_pc      = pc_sum;
        end
      end
      OPC_LOAD: begin
        res_nxt.dest_index      = rd;
        res_nxt.mem_kind        = MEM_LOAD;
        res_nxt.mem_width       = acc_width;
        res_nxt.mem_zero_extend = f3[2];
        res_nxt.mem_address     = addr_sum;
      end
      OPC_STORE: begin
        res_nxt.mem_kind    = MEM_STORE;
        res_nxt.mem_width   = acc_width;
        res_nxt.mem_address = addr_sum;
        res_nxt.store_value = s1_req_r.src2_value;
      end
      OPC_OPIMM, OPC_OP: begin
        res_nxt.dest_index   = rd;
        res_nxt.result_value = alu_res;
        writes               = 1'b1;
      end
      default: begin
        res_nxt.unknown_opcode = 1'b1;
      end
    endcase
    // Writes to x0 are dropped and leave a zero result.
    if (writes && (rd != 5'd0)) begin
      res_nxt.dest_write = 1'b1;
    end else begin
      res_nxt.result_value = '0;
    end
  end

  // Result channel outputs.
  assign out_res.valid           = out_valid_r;
  assign out_res.dest_index      = res_r.dest_index;
  assign out_res.dest_write      = res_r.dest_write;
  assign out_res.result_value    = res_r.result_value;
  assign out_res.next_pc         = res_r.next_pc;
  assign out_res.branch_taken    = res_r.branch_taken;
  assign out_res.mem_kind        = res_r.mem_kind;
  assign out_res.mem_width       = res_r.mem_width;
  assign out_res.mem_zero_extend = res_r.mem_zero_extend;
  assign out_res.mem_address     = res_r.mem_address;
  assign out_res.store_value     = res_r.store_value;
  assign out_res.unknown_opcode  = res_r.unknown_opcode;

  // Checks on the pipeline and on the decoded result.
  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_valid_r && !s1_valid_r)
    else $error("pipeline not empty after reset");

  a_take_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
      in_req.valid && in_req.ready |=> s1_valid_r)
    else $error("taken request did not reach the request register");

  a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid_r && res_r.dest_write |-> res_r.dest_index != 5'd0)
    else $error("write enable raised for x0");

  a_unknown_quiet: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid_r && res_r.unknown_opcode |->
        !res_r.dest_write && (res_r.mem_kind == MEM_NONE) && !res_r.branch_taken)
    else $error("unknown opcode produced side effects");

  a_no_access_quiet: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid_r && (res_r.mem_kind == MEM_NONE) |->
        (res_r.mem_address == 32'd0) && (res_r.store_value == 32'd0))
    else $error("address or store data set without a memory access");

endmodule

/* tb/tb_rv32i_execute_unit.sv */
// Self-checking testbench for the RV32I execute unit with a local instruction predictor.
`timescale 1ns / 100ps

module tb_rv32i_execute_unit;
  import rvex_pkg::*;

  // Load, store and branch function codes and the funct7 patterns used in stimulus.
  localparam logic [2:0] F3_LB  = 3'd0;
  localparam logic [2:0] F3_LW  = 3'd2;
  localparam logic [2:0] F3_LD_UNUSED = 3'd3;
  localparam logic [2:0] F3_LHU = 3'd5;
  localparam logic [2:0] F3_LD_UNUSED_HI = 3'd7;
  localparam logic [2:0] F3_SB  = 3'd0;
  localparam logic [2:0] F3_ST_UNUSED = 3'd7;
  localparam logic [2:0] F3_BR_UNUSED = 3'd2;
  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [6:0] F7_ALL  = 7'h7f;

  localparam int unsigned HOLD_CYCLES = 160;
  localparam int unsigned RANDOM_ITEMS = 1330;

  // One queued request with the idle cycles that precede it.
  typedef struct packed {
    ex_req_t    req;
    logic [4:0] gap;
    logic       drain;
  } feed_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rvex_req_if req_ch ();
  rvex_res_if res_ch ();

  rv32i_execute_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_res (res_ch)
  );

  feed_t       instr_feed[$];
  ex_res_t     pending_results[$];
  feed_t       next_req;
  bit          have_next = 1'b0;
  int unsigned req_taken = 0;
  int unsigned results_seen = 0;
  int unsigned fail_count = 0;
  int unsigned tx_mode = 1;
  int unsigned rx_mode = 1;
  int unsigned rx_wait = 0;
  int unsigned hold_left = 0;
  int unsigned next_hold_at = 250;
  ex_req_t     taken_req;
  ex_res_t     got_res;

  always #2 clk = ~clk;

  // Known values on every block input from time zero.
  initial begin
    req_ch.valid      = 1'b0;
    req_ch.instr_word = '0;
    req_ch.cur_pc     = '0;
    req_ch.src1_value = '0;
    req_ch.src2_value = '0;
    res_ch.ready      = 1'b0;
  end

  // Idle cycles for one request: none, any from 0 to 18, or mostly none.
  function automatic int unsigned draw_wait(int unsigned mode);
    if (mode == 0)
      return 0;
    else if (mode == 1)
      return $urandom_range(0, 18);
    else
      return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 18) : 0;
  endfunction

  // Integer ALU shared by OP and OP-IMM; only bit 30 of funct7 reaches here.
  function automatic logic [31:0] alu_result(logic [2:0] f3, logic sub_en, logic sra_en,
                                             logic [31:0] a, logic [31:0] b);
    logic [4:0] sh;
    sh = b[4:0];
    case (f3)
      F3_ADD:  return sub_en ? a - b : a + b;
      F3_SLL:  return a << sh;
      F3_SLT:  return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
      F3_SLTU: return (a < b) ? 32'd1 : 32'd0;
      F3_XOR:  return a ^ b;
      F3_SR:   return sra_en ? 32'($signed(a) >>> sh) : a >> sh;
      F3_OR:   return a | b;
      default: return a & b;
    endcase
  endfunction

  // Expected outcome of executing one instruction.
  function automatic ex_res_t exec_outcome(ex_req_t r);
    logic [6:0]  opc;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic        alt;
    logic [31:0] ins, a, b, imm_i, imm_s, imm_b, imm_u, imm_j, val;
    logic        wr, cond;
    ex_res_t     o;
    ins   = r.instr_word;
    a     = r.src1_value;
    b     = r.src2_value;
    opc   = ins[6:0];
    rd    = ins[11:7];
    f3    = ins[14:12];
    alt   = ins[30];
    imm_i = {{20{ins[31]}}, ins[31:20]};
    imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
    imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
    imm_u = {ins[31:12], 12'd0};
    imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
    o = '0;
    o.next_pc = r.cur_pc + 32'd4;
    val = '0;
    wr = 1'b0;
    cond = 1'b0;
    case (opc)
      OPC_LUI: begin
        o.dest_index = rd;
        val = imm_u;
        wr = 1'b1;
      end
      OPC_AUIPC: begin
        o.dest_index = rd;
        val = r.cur_pc + imm_u;
        wr = 1'b1;
      end
      OPC_JAL: begin
        o.dest_index = rd;
        val = r.cur_pc + 32'd4;
        o.next_pc = r.cur_pc + imm_j;
        wr = 1'b1;
      end
      OPC_JALR: begin
        o.dest_index = rd;
        val = r.cur_pc + 32'd4;
        o.next_pc = (a + imm_i) & ~32'd1;
        wr = 1'b1;
      end
      OPC_BRANCH: begin
        case (f3)
          F3_BEQ:  cond = (a == b);
          F3_BNE:  cond = (a != b);
          F3_BLT:  cond = ($signed(a) < $signed(b));
          F3_BGE:  cond = !($signed(a) < $signed(b));
          F3_BLTU: cond = (a < b);
          F3_BGEU: cond = (a >= b);
          default: cond = 1'b0;
        endcase
        if (cond) begin
          o.branch_taken = 1'b1;
          o.next_pc = r.cur_pc + imm_b;
        end
      end
      OPC_LOAD: begin
        o.dest_index = rd;
        o.mem_kind = MEM_LOAD;
        o.mem_width = (f3[1:0] > MW_WORD) ? MW_WORD : f3[1:0];
        o.mem_zero_extend = f3[2];
        o.mem_address = a + imm_i;
      end
      OPC_STORE: begin
        o.mem_kind = MEM_STORE;
        o.mem_width = (f3[1:0] > MW_WORD) ? MW_WORD : f3[1:0];
        o.mem_address = a + imm_s;
        o.store_value = b;
      end
      OPC_OPIMM: begin
        o.dest_index = rd;
        val = alu_result(f3, 1'b0, alt, a, imm_i);
        wr = 1'b1;
      end
      OPC_OP: begin
        o.dest_index = rd;
        val = alu_result(f3, alt, alt, a, b);
        wr = 1'b1;
      end
      default: o.unknown_opcode = 1'b1;
    endcase
    // Results to x0 are dropped, and a dropped result reads as zero.
    if (wr && rd != 5'd0) begin
      o.dest_write = 1'b1;
      o.result_value = val;
    end
    return o;
  endfunction

  // Instruction encoders for the directed part.
  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [2:0] f3, logic [4:0] rd,
                                        logic [6:0] opc);
    return {imm, 5'd1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [2:0] f3);
    return {imm[11:5], 5'd2, 5'd1, f3, imm[4:0], OPC_STORE};
  endfunction

  function automatic logic [31:0] enc_b(logic [12:0] imm, logic [2:0] f3);
    return {imm[12], imm[10:5], 5'd2, 5'd1, f3, imm[4:1], imm[11], OPC_BRANCH};
  endfunction

  function automatic logic [31:0] enc_u(logic [19:0] imm, logic [4:0] rd, logic [6:0] opc);
    return {imm, rd, opc};
  endfunction

  function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
  endfunction

  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [2:0] f3, logic [4:0] rd);
    return {f7, 5'd2, 5'd1, f3, rd, OPC_OP};
  endfunction

  // Mostly well-formed instructions with random fields, plus some noise words.
  function automatic logic [31:0] rand_instr();
    logic [31:0] w;
    int unsigned pick;
    w = $urandom();
    pick = $urandom_range(0, 39);
    if (pick == 0)
      return '0;
    if (pick < 3)
      return w;
    case (pick % 9)
      0: w[6:0] = OPC_LUI;
      1: w[6:0] = OPC_AUIPC;
      2: w[6:0] = OPC_JAL;
      3: w[6:0] = OPC_JALR;
      4: w[6:0] = OPC_BRANCH;
      5: w[6:0] = OPC_LOAD;
      6: w[6:0] = OPC_STORE;
      7: w[6:0] = OPC_OPIMM;
      default: w[6:0] = OPC_OP;
    endcase
    // Register ops and immediate shifts usually carry a legal funct7.
    if ((w[6:0] == OPC_OP || (w[6:0] == OPC_OPIMM && (w[14:12] == F3_SLL ||
         w[14:12] == F3_SR))) && $urandom_range(0, 3) != 0)
      w[31:25] = $urandom_range(0, 1) ? F7_ALT : F7_BASE;
    if ($urandom_range(0, 15) == 0)
      w[11:7] = 5'd0;
    return w;
  endfunction

  // Operand values biased towards the signed and unsigned extremes.
  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      4: return $urandom_range(0, 40);
      default: return $urandom();
    endcase
  endfunction

  task automatic add_item(logic [31:0] ins, logic [31:0] pc, logic [31:0] a, logic [31:0] b,
                          bit drain);
    feed_t f;
    f.req.instr_word = ins;
    f.req.cur_pc = pc;
    f.req.src1_value = a;
    f.req.src2_value = b;
    f.gap = 5'(draw_wait(tx_mode));
    f.drain = drain;
    instr_feed.push_back(f);
  endtask

  task automatic report_failure(string msg);
    fail_count++;
    if (fail_count <= 10)
      $display("%s", msg);
  endtask

  function automatic string fmt_res(ex_res_t r);
    return $sformatf({"rd=%0d wr=%0d res=%h npc=%h tk=%0d kind=%0d w=%0d zx=%0d ",
                      "addr=%h st=%h unk=%0d"},
                     r.dest_index, r.dest_write, r.result_value, r.next_pc, r.branch_taken,
                     r.mem_kind, r.mem_width, r.mem_zero_extend, r.mem_address,
                     r.store_value, r.unknown_opcode);
  endfunction

  // Compare one result with the oldest outstanding expectation.
  task automatic check_result(ex_res_t got);
    ex_res_t want;
    string   bad;
    bad = "";
    if (pending_results.size() == 0) begin
      report_failure($sformatf("t=%0t unexpected result: %s", $time, fmt_res(got)));
    end else begin
      want = pending_results.pop_front();
      if (got.dest_index !== want.dest_index) bad = {bad, " dest_index"};
      if (got.dest_write !== want.dest_write) bad = {bad, " dest_write"};
      if (got.result_value !== want.result_value) bad = {bad, " result_value"};
      if (got.next_pc !== want.next_pc) bad = {bad, " next_pc"};
      if (got.branch_taken !== want.branch_taken) bad = {bad, " branch_taken"};
      if (got.mem_kind !== want.mem_kind) bad = {bad, " mem_kind"};
      if (got.mem_width !== want.mem_width) bad = {bad, " mem_width"};
      if (got.mem_zero_extend !== want.mem_zero_extend) bad = {bad, " mem_zero_extend"};
      if (got.mem_address !== want.mem_address) bad = {bad, " mem_address"};
      if (got.store_value !== want.store_value) bad = {bad, " store_value"};
      if (got.unknown_opcode !== want.unknown_opcode) bad = {bad, " unknown_opcode"};
      if (bad != "")
        report_failure($sformatf("t=%0t mismatch in%s\n  expected: %s\n  actual:   %s",
                                 $time, bad, fmt_res(want), fmt_res(got)));
    end
  endtask

  // Request driver: records each accepted request and offers the next one after its gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        taken_req.instr_word = req_ch.instr_word;
        taken_req.cur_pc = req_ch.cur_pc;
        taken_req.src1_value = req_ch.src1_value;
        taken_req.src2_value = req_ch.src2_value;
        pending_results.push_back(exec_outcome(taken_req));
        req_taken++;
      end
      if (!(req_ch.valid && !req_ch.ready)) begin
        if (!have_next && instr_feed.size() != 0) begin
          next_req = instr_feed.pop_front();
          have_next = 1'b1;
        end
        if (!have_next) begin
          req_ch.valid <= 1'b0;
        end else if (next_req.gap != 0) begin
          next_req.gap = next_req.gap - 5'd1;
          req_ch.valid <= 1'b0;
        end else if (next_req.drain && pending_results.size() != 0) begin
          req_ch.valid <= 1'b0;
        end else begin
          req_ch.valid <= 1'b1;
          req_ch.instr_word <= next_req.req.instr_word;
          req_ch.cur_pc <= next_req.req.cur_pc;
          req_ch.src1_value <= next_req.req.src1_value;
          req_ch.src2_value <= next_req.req.src2_value;
          have_next = 1'b0;
        end
      end
    end
  end

  // Long receiver hold-offs while the sender keeps going, so the pipeline backs up.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (req_taken >= next_hold_at) begin
      hold_left <= HOLD_CYCLES;
      next_hold_at = next_hold_at + 650;
    end
  end

  // Result monitor: checks each accepted result, then stalls for a drawn number of cycles.
  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got_res.dest_index = res_ch.dest_index;
        got_res.dest_write = res_ch.dest_write;
        got_res.result_value = res_ch.result_value;
        got_res.next_pc = res_ch.next_pc;
        got_res.branch_taken = res_ch.branch_taken;
        got_res.mem_kind = res_ch.mem_kind;
        got_res.mem_width = res_ch.mem_width;
        got_res.mem_zero_extend = res_ch.mem_zero_extend;
        got_res.mem_address = res_ch.mem_address;
        got_res.store_value = res_ch.store_value;
        got_res.unknown_opcode = res_ch.unknown_opcode;
        check_result(got_res);
        results_seen++;
        if (results_seen % 100 == 0)
          rx_mode = $urandom_range(0, 2);
        rx_wait = draw_wait(rx_mode);
      end
      if (hold_left != 0) begin
        res_ch.ready <= 1'b0;
      end else if (rx_wait != 0) begin
        rx_wait--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    logic [31:0] ins, pc, a, b;
    // Directed part: field extremes, every instruction group and the odd encodings.
    add_item(32'h0000_0000, 32'hffff_fffc, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
    add_item(32'hffff_ffff, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
    add_item(enc_u(20'hfffff, 5'd31, OPC_LUI), 32'h0000_1000, 32'h1, 32'h2, 1'b0);
    add_item(enc_u(20'h12345, 5'd0, OPC_LUI), 32'h0000_1004, 32'h1, 32'h2, 1'b0);
    add_item(enc_u(20'h00001, 5'd5, OPC_AUIPC), 32'hffff_f000, 32'h0, 32'h0, 1'b0);
    add_item(enc_j(21'h100000, 5'd1), 32'h0000_0010, 32'h0, 32'h0, 1'b0);
    add_item(enc_j(21'h0ffffe, 5'd0), 32'hfff0_0000, 32'h0, 32'h0, 1'b0);
    add_item(enc_i(12'hfff, 3'd7, 5'd1, OPC_JALR), 32'h0000_2000, 32'h0000_1001, 32'h0,
             1'b0);
    add_item(enc_b(13'h1ffe, F3_BEQ), 32'h0000_0000, 32'hdead_beef, 32'hdead_beef, 1'b0);
    add_item(enc_b(13'h1000, F3_BNE), 32'h0000_4000, 32'hdead_beef, 32'hdead_beef, 1'b0);
    add_item(enc_b(13'h0ffe, F3_BLT), 32'hffff_f000, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
    add_item(enc_b(13'h0010, F3_BGE), 32'h0000_4000, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
    add_item(enc_b(13'h0010, F3_BLTU), 32'h0000_4000, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
    add_item(enc_b(13'h1000, F3_BGEU), 32'h0000_0100, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
    add_item(enc_b(13'h0010, F3_BR_UNUSED), 32'h0000_4000, 32'h5, 32'h5, 1'b0);
    add_item(enc_i(12'h001, F3_LB, 5'd7, OPC_LOAD), 32'h0, 32'hffff_ffff, 32'h0, 1'b0);
    add_item(enc_i(12'h800, F3_LHU, 5'd8, OPC_LOAD), 32'h0, 32'h0000_0000, 32'h0, 1'b0);
    add_item(enc_i(12'h7ff, F3_LW, 5'd9, OPC_LOAD), 32'h0, 32'h7fff_ffff, 32'h0, 1'b0);
    add_item(enc_i(12'h123, F3_LD_UNUSED, 5'd0, OPC_LOAD), 32'h0, 32'h1000, 32'h0, 1'b0);
    add_item(enc_i(12'h456, F3_LD_UNUSED_HI, 5'd10, OPC_LOAD), 32'h0, 32'h1000, 32'h0,
             1'b0);
    add_item(enc_s(12'hfff, F3_SB), 32'h0, 32'h0000_0000, 32'hcafe_f00d, 1'b0);
    add_item(enc_s(12'h7ff, F3_ST_UNUSED), 32'h0, 32'h8000_0000, 32'hffff_ffff, 1'b0);
    add_item(enc_r(F7_ALT, F3_ADD, 5'd3), 32'h0, 32'h0000_0000, 32'h0000_0001, 1'b0);
    add_item(enc_r(F7_ALL, F3_SR, 5'd4), 32'h0, 32'h8000_0000, 32'hffff_ffff, 1'b0);
    add_item(enc_i({F7_ALT, 5'd31}, F3_SR, 5'd5, OPC_OPIMM), 32'h0, 32'h8000_0000, 32'h0,
             1'b0);
    add_item(enc_i(12'hfff, F3_SLT, 5'd6, OPC_OPIMM), 32'h0, 32'h8000_0000, 32'h0, 1'b1);

    // Random part, with the idle style of the sender changing every so often.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0)
        tx_mode = $urandom_range(0, 2);
      ins = rand_instr();
      a = rand_operand();
      b = ($urandom_range(0, 5) == 0) ? a : rand_operand();
      pc = $urandom_range(0, 1) ? $urandom() : ($urandom() & 32'h0000_fffc);
      add_item(ins, pc, a, b, (n % 300 == 299));
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (instr_feed.size() != 0 || have_next || req_ch.valid)
      @(posedge clk);
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    if (fail_count == 0 && pending_results.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
